[src/sed_pkg.sv]
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, character codes and decode helpers for the string escape
// decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

    // Escape phase, one-hot coded.
    typedef enum logic [3:0] {
        PH_PLAIN = 4'b0001,
        PH_ESC   = 4'b0010,
        PH_HEX   = 4'b0100,
        PH_OCT   = 4'b1000
    } phase_t;

    // One decoded result word as it waits in the output stage.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } result_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [1:0] OCT_MAX      = 2'd3;

    // True for the octal digits 0 to 7.
    function automatic logic is_oct(input logic [7:0] c);
        return c inside {[8'h30:8'h37]};
    endfunction

    // True for hex digits in either case.
    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Nibble value of a hex digit; only meaningful when is_hex holds.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    // Simple escapes map to control codes; anything else stands for itself.
    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'h0A; // n
            8'h74:   r = 8'h09; // t
            8'h72:   r = 8'h0D; // r
            8'h61:   r = 8'h07; // a
            8'h62:   r = 8'h08; // b
            8'h66:   r = 8'h0C; // f
            8'h76:   r = 8'h0B; // v
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

[src/string_escape_decoder.sv]
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes the body bytes of a C string literal into the bytes they denote.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one raw body byte per word on s_tdata, with s_tlast
// high on the final byte of the literal. The master channel gives decoded
// bytes on m_tdata; m_tuser is high on the last word caused by one input
// word, and m_tlast is high on the final decoded byte of the literal.
// An input word can give no result (a backslash, or a hex or octal digit
// being collected), one result, or two (a pending hex or octal value flushed
// ahead of the byte that ended it).
// A word accepted into the input register is decoded once the output stage
// will be empty; its first result is shown on the master side from then on.
// Throughput: one input word per cycle while m_tready is high; a word that
// gives two results holds the input register while the two-word output stage drains.
// A stalled receiver fills the output stage and then the input register,
// after which s_tready goes low; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties both stages and returns the
// decoder to the plain-text phase.
// ----------------------------------------------------------------------------
module string_escape_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    // Input channel.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // end_of_text
    // Result channel.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_out
    output logic       m_tuser,   // [0] run_end
    output logic       m_tlast    // text_end
);
    import sed_pkg::*;

    // Input register.
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    logic       in_valid_reg, in_valid_next;

    // Decoder state.
    phase_t     phase_reg, phase_next;
    logic [7:0] accum_reg, accum_next;
    logic       hex_seen_reg, hex_seen_next;
    logic [1:0] oct_cnt_reg, oct_cnt_next;

    // Output stage: up to two results, slot 0 shown first.
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] out_cnt_reg, out_cnt_next;

    logic       advance;
    logic       out_pop;
    logic [7:0] res0, res1;
    logic [1:0] nres;
    logic       pre_v, do_plain, plain_emit, end_emit;
    logic [7:0] pre_b, end_b;

    // The input word is decoded once the output stage will be empty.
    assign out_pop  = m_tvalid && m_tready;
    assign advance  = in_valid_reg &&
                      ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_tready));
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg.data;
    assign m_tuser  = slot0_reg.run_end;
    assign m_tlast  = slot0_reg.text_end;

    // Escape decoding for one input word.
    always_comb begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        hex_seen_next = hex_seen_reg;
        oct_cnt_next  = oct_cnt_reg;
        pre_v         = 1'b0;
        pre_b         = in_char_reg;
        do_plain      = 1'b0;
        plain_emit    = 1'b0;
        end_emit      = 1'b0;
        end_b         = accum_reg;

        case (phase_reg)
            PH_PLAIN: begin
                do_plain = 1'b1;
            end
            PH_ESC: begin
                if (in_char_reg == CH_X) begin
                    phase_next    = PH_HEX;
                    accum_next    = 8'd0;
                    hex_seen_next = 1'b0;
                end else if (is_oct(in_char_reg)) begin
                    phase_next   = PH_OCT;
                    accum_next   = {5'd0, in_char_reg[2:0]};
                    oct_cnt_next = 2'd1;
                end else begin
                    pre_v      = 1'b1;
                    pre_b      = simple_escape(in_char_reg);
                    phase_next = PH_PLAIN;
                end
            end
            PH_HEX: begin
                if (is_hex(in_char_reg)) begin
                    accum_next    = {accum_reg[3:0], hex_val(in_char_reg)};
                    hex_seen_next = 1'b1;
                end else begin
                    // Flush the pending value, then treat the byte as plain.
                    pre_v         = 1'b1;
                    pre_b         = hex_seen_reg ? accum_reg : CH_X;
                    phase_next    = PH_PLAIN;
                    accum_next    = 8'd0;
                    hex_seen_next = 1'b0;
                    oct_cnt_next  = 2'd0;
                    do_plain      = 1'b1;
                end
            end
            PH_OCT: begin
                if (is_oct(in_char_reg)) begin
                    accum_next   = {accum_reg[4:0], in_char_reg[2:0]};
                    oct_cnt_next = oct_cnt_reg + 2'd1;
                    // The third digit closes the escape at once.
                    if (oct_cnt_next == OCT_MAX) begin
                        pre_v         = 1'b1;
                        pre_b         = accum_next;
                        phase_next    = PH_PLAIN;
                        accum_next    = 8'd0;
                        hex_seen_next = 1'b0;
                        oct_cnt_next  = 2'd0;
                    end
                end else begin
                    pre_v         = 1'b1;
                    pre_b         = accum_reg;
                    phase_next    = PH_PLAIN;
                    accum_next    = 8'd0;
                    hex_seen_next = 1'b0;
                    oct_cnt_next  = 2'd0;
                    do_plain      = 1'b1;
                end
            end
            default: begin
                phase_next = PH_PLAIN;
            end
        endcase

        // Plain handling; a backslash on the final byte is kept literally.
        if (do_plain) begin
            if ((in_char_reg == CH_BACKSLASH) && !in_end_reg) begin
                phase_next = PH_ESC;
            end else begin
                plain_emit = 1'b1;
            end
        end

        // End of text flushes a pending value and restarts the decoder.
        if (in_end_reg) begin
            if (phase_next == PH_HEX) begin
                end_emit = 1'b1;
                end_b    = hex_seen_next ? accum_next : CH_X;
            end else if (phase_next == PH_OCT) begin
                end_emit = 1'b1;
                end_b    = accum_next;
            end
            phase_next    = PH_PLAIN;
            accum_next    = 8'd0;
            hex_seen_next = 1'b0;
            oct_cnt_next  = 2'd0;
        end
    end

    // Collect the results of this word in order.
    always_comb begin
        res0 = pre_b;
        res1 = in_char_reg;
        nres = 2'd0;
        if (pre_v) begin
            res0 = pre_b;
            nres = 2'd1;
        end
        if (plain_emit) begin
            if (pre_v) begin
                res1 = in_char_reg;
                nres = 2'd2;
            end else begin
                res0 = in_char_reg;
                nres = 2'd1;
            end
        end
        if (end_emit) begin
            res0 = end_b;
            nres = 2'd1;
        end
    end

    // Next values of the input register and the output stage.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        slot0_next   = slot0_reg;
        slot1_next   = slot1_reg;
        out_cnt_next = out_cnt_reg;
        if (advance) begin
            out_cnt_next = nres;
            if (nres == 2'd2) begin
                slot0_next = '{data: res0, run_end: 1'b0, text_end: 1'b0};
                slot1_next = '{data: res1, run_end: 1'b1, text_end: in_end_reg};
            end else begin
                slot0_next = '{data: res0, run_end: 1'b1, text_end: in_end_reg};
            end
        end else if (out_pop) begin
            slot0_next   = slot1_reg;
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_cnt_reg  <= 2'd0;
            phase_reg    <= PH_PLAIN;
            accum_reg    <= 8'd0;
            hex_seen_reg <= 1'b0;
            oct_cnt_reg  <= 2'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_cnt_reg  <= out_cnt_next;
            if (advance) begin
                phase_reg    <= phase_next;
                accum_reg    <= accum_next;
                hex_seen_reg <= hex_seen_next;
                oct_cnt_reg  <= oct_cnt_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[src/string_escape_decoder_checker.sv]
// ----------------------------------------------------------------------------
// string_escape_decoder_checker
// Port-level checks on the string escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module string_escape_decoder_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled result word holds its value and flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result word changed");

    // The end of the literal is always the last result of its input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("text end without run end");

    // The input only stalls while a result is waiting on the master side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // Reset empties the output stage.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

bind string_escape_decoder string_escape_decoder_checker u_checker (.*);
